/* hdl/adb_pkg.sv */
// Package for the adaptive box decimator: field widths, register map,
// reset values, steering constants and controller/datapath link types.
// No dependencies.
package adb_pkg;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int MARK_W   = 16;
  localparam int RATIO_W  = 24;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // ratio arithmetic, Q8.16
  localparam logic [RATIO_W-1:0] ONE_Q16   = 24'h010000;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;
  localparam int STEER_W     = 8;
  localparam logic [STEER_W-1:0] STEER_NUM = 8'd131;
  localparam int STEER_SHIFT = 15;
  localparam int PROD_W      = RATIO_W + STEER_W;
  localparam int DELTA_W     = PROD_W - STEER_SHIFT;

  // register map: word index = paddr[3:2]
  localparam logic [1:0] REG_STEP_RATIO = 2'd0;
  localparam logic [1:0] REG_LOW_MARK   = 2'd1;
  localparam logic [1:0] REG_HIGH_MARK  = 2'd2;

  // reset values
  localparam logic [RATIO_W-1:0] STEP_RATIO_RESET = 24'd2659741;
  localparam logic [MARK_W-1:0]  LOW_MARK_RESET   = 16'd2048;
  localparam logic [MARK_W-1:0]  HIGH_MARK_RESET  = 16'd4096;

  // input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam int DEFAULT_MAX_WINDOW = 256;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic steer;
    logic update;
    logic out_load;
  } adb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic close;
    logic div_done;
    logic out_free;
  } adb_status_t;

endpackage

/* hdl/adb_divider.sv */
// Restoring divider for the window mean: one quotient bit per cycle,
// result truncated toward zero. Depends on adb_pkg.
module adb_divider #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [SUM_W-1:0]      dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         busy,
  output logic                         done,
  output logic [adb_pkg::SAMPLE_W-1:0] quotient
);
  import adb_pkg::*;

  localparam int ITER_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic              neg;
  logic [ITER_W-1:0] iter;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  quot_signed;

  // one restoring step
  always_comb begin
    trial = {rem, quot[SUM_W-1]};
    fits  = (trial >= {1'b0, den});
  end

  // load operands, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(SUM_W - 1);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_W-1];
      quot <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      den  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fits ? CNT_W'(trial - {1'b0, den}) : CNT_W'(trial);
      quot <= {quot[SUM_W-2:0], fits};
    end
  end

  // apply sign of the sum
  assign quot_signed = neg ? (~quot + 1'b1) : quot;
  assign quotient    = quot_signed[SAMPLE_W-1:0];

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

/* hdl/adb_datapath.sv */
// Datapath of the adaptive box decimator: input latch, ratio steering,
// window accumulator, phase, mean divider and output register.
// Depends on adb_pkg and adb_divider.
module adb_datapath #(
  parameter int MAX_WINDOW = adb_pkg::DEFAULT_MAX_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  adb_pkg::adb_cmd_t                  cmd,
  output adb_pkg::adb_status_t               status,
  input  logic                               op,
  input  logic signed [adb_pkg::SAMPLE_W-1:0] sample,
  input  logic [adb_pkg::LEVEL_W-1:0]        queue_level,
  input  logic [adb_pkg::RATIO_W-1:0]        step_ratio,
  input  logic [adb_pkg::MARK_W-1:0]         low_mark,
  input  logic [adb_pkg::MARK_W-1:0]         high_mark,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [adb_pkg::SAMPLE_W-1:0] average
);
  import adb_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  // latched input word
  logic                       op_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic [LEVEL_W-1:0]         level_r;

  // steering
  logic [PROD_W-1:0]          prod;
  logic [DELTA_W-1:0]         delta;
  logic [RATIO_W:0]           ratio_up;
  logic [RATIO_W-1:0]         ratio_dn;
  logic [RATIO_W:0]           ratio_sel;
  logic [RATIO_W-1:0]         ratio_next;
  logic [RATIO_W-1:0]         ratio;

  // window state
  logic [RATIO_W-1:0]         phase;
  logic signed [SUM_W-1:0]    window_sum;
  logic [CNT_W-1:0]           window_count;
  logic [RATIO_W:0]           p;
  logic signed [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]           count_next;
  logic [RATIO_W-1:0]         phase_next;
  logic                       hit_ratio;
  logic                       hit_full;

  logic                       div_busy;
  logic [SAMPLE_W-1:0]        div_q;

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op;
      sample_r <= sample;
      level_r  <= queue_level;
    end
  end

  // steering amount, refreshed every cycle from the ratio register
  assign prod = PROD_W'(step_ratio) * PROD_W'(STEER_NUM);
  always_ff @(posedge clk) begin
    delta <= prod[PROD_W-1:STEER_SHIFT];
  end

  // pick and clamp the effective ratio
  always_comb begin
    ratio_up = {1'b0, step_ratio} + (RATIO_W + 1)'(delta);
    ratio_dn = step_ratio - RATIO_W'(delta);
    if (level_r > high_mark) begin
      ratio_sel = ratio_up;
    end else if (level_r < low_mark) begin
      ratio_sel = {1'b0, ratio_dn};
    end else begin
      ratio_sel = {1'b0, step_ratio};
    end
    if (ratio_sel > {1'b0, RATIO_MAX}) begin
      ratio_next = RATIO_MAX;
    end else if (ratio_sel < {1'b0, ONE_Q16}) begin
      ratio_next = ONE_Q16;
    end else begin
      ratio_next = ratio_sel[RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.steer) begin
      ratio <= ratio_next;
    end
  end

  // accumulate and advance the phase
  always_comb begin
    sum_next   = window_sum + SUM_W'(signed'(sample_r));
    count_next = window_count + 1'b1;
    p          = {1'b0, phase} + (RATIO_W + 1)'(ONE_Q16);
    hit_ratio  = (p >= {1'b0, ratio});
    hit_full   = (count_next >= CNT_W'(MAX_WINDOW));
    if (hit_ratio) begin
      phase_next = RATIO_W'(p - {1'b0, ratio});
    end else if (hit_full) begin
      phase_next = '0;
    end else begin
      phase_next = p[RATIO_W-1:0];
    end
  end

  assign status.close = cmd.update && (op_r == OP_SAMPLE) && (hit_ratio || hit_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      window_sum   <= '0;
      window_count <= '0;
    end else if (cmd.update) begin
      if (op_r == OP_CLEAR) begin
        phase        <= '0;
        window_sum   <= '0;
        window_count <= '0;
      end else begin
        phase <= phase_next;
        if (status.close) begin
          window_sum   <= '0;
          window_count <= '0;
        end else begin
          window_sum   <= sum_next;
          window_count <= count_next;
        end
      end
    end
  end

  // mean of the closed window
  adb_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (status.close),
    .dividend (sum_next),
    .divisor  (count_next),
    .busy     (div_busy),
    .done     (status.div_done),
    .quotient (div_q)
  );

  // output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= div_q;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      window_count <= CNT_W'(MAX_WINDOW))
    else $error("window count beyond maximum window");

  assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> !div_busy)
    else $error("result loaded while divider still running");

endmodule

/* hdl/adb_ctrl.sv */
// Controller of the adaptive box decimator: sequences accept, steer,
// update, divide and push. Depends on adb_pkg.
module adb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  adb_pkg::adb_status_t status,
  output adb_pkg::adb_cmd_t    cmd
);
  import adb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEER  = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PUSH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.steer    = 1'b0;
    cmd.update   = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_STEER;
        end
      end
      S_STEER: begin
        cmd.steer  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.close ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      cmd.out_load |-> status.out_free)
    else $error("result pushed over an unread word");

  assert property (@(posedge clk) disable iff (rst)
      (in_valid && in_ready) |=> (state == S_STEER))
    else $error("accepted word not steered next cycle");

endmodule

/* hdl/adaptive_box_decimator_top.sv */
// Top level of the adaptive box decimator: APB register file, controller
// and datapath. Depends on adb_pkg, adb_ctrl and adb_datapath.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_ready    op, sample, queue_level
//  output    out        out_valid/out_ready  average
//  config    in         psel/penable/pready  paddr, pwdata, prdata
//
// A word that closes no window passes through accept, steer and update.
// A word that closes a window also runs the serial mean divider, one quotient
// bit per cycle over the sum width (24 bits at the default window), and
// then the push of the mean into the output register.
// A result waiting in the output register does not block new words; only
// the push of the next result waits for it. Reset is synchronous and clears
// phase, window sum and count and restores the register defaults.
module adaptive_box_decimator_top #(
  parameter int MAX_WINDOW = adb_pkg::DEFAULT_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [adb_pkg::SAMPLE_W-1:0] sample,
  input  logic [adb_pkg::LEVEL_W-1:0]         queue_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [adb_pkg::SAMPLE_W-1:0] average,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adb_pkg::ADDR_W-1:0]          paddr,
  input  logic [adb_pkg::DATA_W-1:0]          pwdata,
  output logic [adb_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import adb_pkg::*;

  logic [RATIO_W-1:0] step_ratio;
  logic [MARK_W-1:0]  low_mark;
  logic [MARK_W-1:0]  high_mark;
  logic               wr_en;
  logic [1:0]         reg_idx;

  adb_cmd_t    cmd;
  adb_status_t status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RATIO_RESET;
      low_mark   <= LOW_MARK_RESET;
      high_mark  <= HIGH_MARK_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_RATIO: step_ratio <= pwdata[RATIO_W-1:0];
        REG_LOW_MARK:   low_mark   <= pwdata[MARK_W-1:0];
        REG_HIGH_MARK:  high_mark  <= pwdata[MARK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_STEP_RATIO: prdata = DATA_W'(step_ratio);
      REG_LOW_MARK:   prdata = DATA_W'(low_mark);
      REG_HIGH_MARK:  prdata = DATA_W'(high_mark);
      default:        prdata = '0;
    endcase
  end

  adb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  adb_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op          (op),
    .sample      (sample),
    .queue_level (queue_level),
    .step_ratio  (step_ratio),
    .low_mark    (low_mark),
    .high_mark   (high_mark),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .average     (average)
  );

endmodule
